// ===== src/fbfa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfa_pkg - shared types and codes of the free block fit allocator
// Action and status codes, and the control and scan flag groups that
// travel between the top level and the row of table cells.
// ----------------------------------------------------------------------------
package fbfa_pkg;

    // action carried in s_axis_tuser
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_REQ = 1'b1;

    // status carried in m_axis_tuser
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_ADDED   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // fit policy
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    // table update command, broadcast to every cell
    typedef struct packed {
        logic add_en;
        logic shift_en;
        logic fit_mode;
    } t_cell_ctl;

    // flags of the search token that walks the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } t_scan_flags;

endpackage

// ===== src/fbfa_cell.sv =====
// ----------------------------------------------------------------------------
// fbfa_cell - one table entry of the free block fit allocator
// Holds one size and handle, updates the passing search token, and takes
// an appended block or its right neighbor's contents on removal.
// ----------------------------------------------------------------------------
module fbfa_cell #(
    parameter int SIZE_BITS   = 32,
    parameter int HANDLE_BITS = 8,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5,
    parameter int CELL_IDX    = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fbfa_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [IDX_W-1:0]       i_pick,
    input  logic [SIZE_BITS-1:0]   i_add_size,
    input  logic [HANDLE_BITS-1:0] i_add_handle,
    input  logic [SIZE_BITS-1:0]   i_nxt_size,
    input  logic [HANDLE_BITS-1:0] i_nxt_handle,
    output logic [SIZE_BITS-1:0]   o_size,
    output logic [HANDLE_BITS-1:0] o_handle,
    input  fbfa_pkg::t_scan_flags  i_scan,
    input  logic [SIZE_BITS-1:0]   i_req_size,
    input  logic [SIZE_BITS-1:0]   i_best_size,
    input  logic [HANDLE_BITS-1:0] i_best_handle,
    input  logic [IDX_W-1:0]       i_best_idx,
    output fbfa_pkg::t_scan_flags  o_scan,
    output logic [SIZE_BITS-1:0]   o_req_size,
    output logic [SIZE_BITS-1:0]   o_best_size,
    output logic [HANDLE_BITS-1:0] o_best_handle,
    output logic [IDX_W-1:0]       o_best_idx
);
    import fbfa_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0]   r_size, n_size;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    t_scan_flags            r_scan;
    logic [SIZE_BITS-1:0]   r_req_size, r_best_size;
    logic [HANDLE_BITS-1:0] r_best_handle;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   occupied;
    logic                   take;

    assign occupied = MY_CNT < i_count;

    // a fitting entry replaces the best so far if none was found yet, or in best fit if strictly smaller
    assign take = i_scan.valid && occupied && (r_size >= i_req_size)
                  && (!i_scan.found
                      || (i_ctl.fit_mode == FIT_BEST && r_size < i_best_size));

    always_comb begin
        n_size   = r_size;
        n_handle = r_handle;
        priority if (i_ctl.add_en && MY_CNT == i_count) begin
            n_size   = i_add_size;
            n_handle = i_add_handle;
        end else if (i_ctl.shift_en && MY_IDX >= i_pick) begin
            n_size   = i_nxt_size;
            n_handle = i_nxt_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size        <= n_size;
        r_handle      <= n_handle;
        r_req_size    <= i_req_size;
        r_best_size   <= take ? r_size : i_best_size;
        r_best_handle <= take ? r_handle : i_best_handle;
        r_best_idx    <= take ? MY_IDX : i_best_idx;
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan.valid <= i_scan.valid;
            r_scan.found <= i_scan.found | take;
        end
    end

    assign o_size        = r_size;
    assign o_handle      = r_handle;
    assign o_scan        = r_scan;
    assign o_req_size    = r_req_size;
    assign o_best_size   = r_best_size;
    assign o_best_handle = r_best_handle;
    assign o_best_idx    = r_best_idx;

endmodule

// ===== src/free_block_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// free_block_fit_allocator_top - first fit / best fit free block allocator
// Ordered table of free blocks held in a row of cells; adds append at the
// tail, requests search the row and remove the granted block in place.
// ----------------------------------------------------------------------------
//  channel    dir  handshake                      payload
//  s_axis     in   s_axis_tvalid / s_axis_tready  tuser: action
//                                                 tdata: block_size, block_handle
//  m_axis     out  m_axis_tvalid / m_axis_tready  tuser: status
//                                                 tdata: granted_handle, granted_size
//  cfg        in   i_cfg_wr_en                    i_cfg_wr_data: fit_mode
//
//  an add item's result is registered at the accept edge
//  a request is registered at the accept edge and injected as a search token
//  that steps one cell per cycle down the row; its result is captured, then
//  S_DONE removes a granted entry and loads the result register once the output is free
//  synchronous active-low reset empties the table and selects first fit
//  a stalled result holds its register; a new item is taken once it leaves
// ----------------------------------------------------------------------------
module free_block_fit_allocator_top #(
    parameter int ENTRIES     = 16,
    parameter int SIZE_BITS   = 32,
    parameter int HANDLE_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,   // fit_mode

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // block_size, block_handle from bit 0 up, zero pad to bytes
    input  logic [((SIZE_BITS+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tuser,    // action

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // granted_handle, granted_size from bit 0 up, zero pad to bytes
    output logic [((SIZE_BITS+HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic [1:0] m_axis_tuser  // status
);
    import fbfa_pkg::*;

    localparam int DATA_W = ((SIZE_BITS + HANDLE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_fit_mode;
    logic                   r_inject;
    logic [SIZE_BITS-1:0]   r_req_size;
    logic                   r_res_found;
    logic [SIZE_BITS-1:0]   r_res_size;
    logic [HANDLE_BITS-1:0] r_res_handle;
    logic [IDX_W-1:0]       r_res_idx;
    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic [SIZE_BITS-1:0]   r_out_size;
    logic [HANDLE_BITS-1:0] r_out_handle;

    logic                   in_accept;
    logic                   out_free;
    logic [SIZE_BITS-1:0]   in_size;
    logic [HANDLE_BITS-1:0] in_handle;
    t_cell_ctl              cell_ctl;

    // search token chain: index 0 is the injection point
    t_scan_flags            scan_flags [ENTRIES+1];
    logic [SIZE_BITS-1:0]   scan_req   [ENTRIES+1];
    logic [SIZE_BITS-1:0]   scan_bsize [ENTRIES+1];
    logic [HANDLE_BITS-1:0] scan_bhdl  [ENTRIES+1];
    logic [IDX_W-1:0]       scan_bidx  [ENTRIES+1];

    // stored contents of each cell, read by its left neighbor on removal
    logic [SIZE_BITS-1:0]   cell_size   [ENTRIES];
    logic [HANDLE_BITS-1:0] cell_handle [ENTRIES];

    assign in_size   = s_axis_tdata[SIZE_BITS-1:0];
    assign in_handle = s_axis_tdata[SIZE_BITS+HANDLE_BITS-1:SIZE_BITS];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // table update: append on an accepted add while not full, close the gap on a grant
    always_comb begin
        cell_ctl.add_en   = in_accept && (s_axis_tuser == ACT_ADD)
                            && (r_count < FULL_CNT);
        cell_ctl.shift_en = (r_state == S_DONE) && out_free && r_res_found;
        cell_ctl.fit_mode = r_fit_mode;
    end

    // token enters cell 0 in the cycle after the request is taken
    assign scan_flags[0].valid = r_inject;
    assign scan_flags[0].found = 1'b0;
    assign scan_req[0]         = r_req_size;
    assign scan_bsize[0]       = '0;
    assign scan_bhdl[0]        = '0;
    assign scan_bidx[0]        = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [SIZE_BITS-1:0]   nxt_size;
        logic [HANDLE_BITS-1:0] nxt_handle;

        if (g < ENTRIES - 1) begin : g_mid
            assign nxt_size   = cell_size[g+1];
            assign nxt_handle = cell_handle[g+1];
        end else begin : g_end
            // last cell pulls in nothing once a gap opens below it
            assign nxt_size   = '0;
            assign nxt_handle = '0;
        end

        fbfa_cell #(
            .SIZE_BITS   (SIZE_BITS),
            .HANDLE_BITS (HANDLE_BITS),
            .IDX_W       (IDX_W),
            .CNT_W       (CNT_W),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_count       (r_count),
            .i_pick        (r_res_idx),
            .i_add_size    (in_size),
            .i_add_handle  (in_handle),
            .i_nxt_size    (nxt_size),
            .i_nxt_handle  (nxt_handle),
            .o_size        (cell_size[g]),
            .o_handle      (cell_handle[g]),
            .i_scan        (scan_flags[g]),
            .i_req_size    (scan_req[g]),
            .i_best_size   (scan_bsize[g]),
            .i_best_handle (scan_bhdl[g]),
            .i_best_idx    (scan_bidx[g]),
            .o_scan        (scan_flags[g+1]),
            .o_req_size    (scan_req[g+1]),
            .o_best_size   (scan_bsize[g+1]),
            .o_best_handle (scan_bhdl[g+1]),
            .o_best_idx    (scan_bidx[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fit_mode  <= FIT_FIRST;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            if (i_cfg_wr_en) begin
                r_fit_mode <= i_cfg_wr_data;
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (s_axis_tuser == ACT_ADD) begin
                            r_out_valid  <= 1'b1;
                            r_out_size   <= '0;
                            r_out_handle <= '0;
                            if (r_count < FULL_CNT) begin
                                r_count      <= r_count + 1'b1;
                                r_out_status <= ST_ADDED;
                            end else begin
                                r_out_status <= ST_FULL;
                            end
                        end else begin
                            r_inject   <= 1'b1;
                            r_req_size <= in_size;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // token has passed the last cell
                    if (scan_flags[ENTRIES].valid) begin
                        r_res_found  <= scan_flags[ENTRIES].found;
                        r_res_size   <= scan_bsize[ENTRIES];
                        r_res_handle <= scan_bhdl[ENTRIES];
                        r_res_idx    <= scan_bidx[ENTRIES];
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_res_found) begin
                            r_out_status <= ST_GRANTED;
                            r_out_size   <= r_res_size;
                            r_out_handle <= r_res_handle;
                            r_count      <= r_count - 1'b1;
                        end else begin
                            r_out_status <= ST_NOFIT;
                            r_out_size   <= '0;
                            r_out_handle <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = DATA_W'({r_out_size, r_out_handle});

endmodule

// ===== src/fbfa_chk.sv =====
// ----------------------------------------------------------------------------
// fbfa_chk - port checker of the free block fit allocator
// Watches the top level's streams and is bound to every instance of it.
// ----------------------------------------------------------------------------
module fbfa_chk #(
    parameter int SIZE_BITS   = 32,
    parameter int HANDLE_BITS = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((SIZE_BITS+HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);
    import fbfa_pkg::*;

    // a result is never shown in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                          && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // only a grant carries a handle and size
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_GRANTED |-> m_axis_tdata == '0)
        else $error("non-grant result with nonzero data");

    // an add item answers in the next cycle with added or full
    a_add_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_ADD
        |=> m_axis_tvalid && (m_axis_tuser == ST_ADDED || m_axis_tuser == ST_FULL))
        else $error("add item not answered in one cycle");

    // a taken request deasserts s_axis_tready before any new item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_REQ |=> !s_axis_tready)
        else $error("item taken during a search");

endmodule

bind free_block_fit_allocator_top fbfa_chk #(
    .SIZE_BITS   (SIZE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_fbfa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
